[rtl/ctit_pkg.sv]
// Shared types and codes for the connection table with idle timeout.
// No dependencies; every other file in rtl/ except ctit_ram imports this package.
package ctit_pkg;

  typedef logic [2:0]  cmd_t;
  typedef logic [1:0]  status_t;
  typedef logic [31:0] addr_t;
  typedef logic [15:0] port_t;
  typedef logic [15:0] pid_t;
  typedef logic [31:0] tick_t;

  localparam cmd_t CMD_PACKET    = 3'd0;
  localparam cmd_t CMD_TICK      = 3'd1;
  localparam cmd_t CMD_SWEEP     = 3'd2;
  localparam cmd_t CMD_EP_FOR_ID = 3'd3;
  localparam cmd_t CMD_ID_FOR_EP = 3'd4;
  localparam cmd_t CMD_LIST      = 3'd5;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_FULL      = 2'd2;
  localparam status_t ST_EMPTY     = 2'd3;

  localparam tick_t TIMEOUT_RST = 32'd5000;

  // One table entry as stored in the entry RAM.
  typedef struct packed {
    addr_t addr;
    port_t port;
    pid_t  pid;
    tick_t seen;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  // Per-entry result of the shared compare unit.
  typedef struct packed {
    logic ep_hit;
    logic id_hit;
    logic expired;
  } cmp_flags_t;

endpackage

[rtl/ctit_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ctit_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/ctit_cmp.sv]
// Shared compare unit: endpoint match, player id match and idle-age test.
// Depends on ctit_pkg.
module ctit_cmp (
  input  ctit_pkg::ent_t       ent,
  input  ctit_pkg::addr_t      key_addr,
  input  ctit_pkg::port_t      key_port,
  input  ctit_pkg::pid_t       key_pid,
  input  ctit_pkg::tick_t      now,
  input  ctit_pkg::tick_t      timeout,
  output ctit_pkg::cmp_flags_t flags
);
  import ctit_pkg::*;

  tick_t idle;

  // Age wraps with the time counter, so a plain modular subtract is right.
  assign idle          = now - ent.seen;
  assign flags.ep_hit  = (ent.addr == key_addr) && (ent.port == key_port);
  assign flags.id_hit  = (ent.pid == key_pid);
  assign flags.expired = (idle >= timeout);

endmodule

[rtl/connection_table_idle_timeout.sv]
// Connection table with idle timeout: TABLE_DEPTH endpoints (IPv4 address and
// UDP port), each tagged with a 16-bit player id and a last-seen tick. Packet,
// sweep and lookup requests run a scan: the sequencer walks the entry RAM one
// entry per cycle through a single shared compare unit and then gives a single
// result. Tick and undefined codes go straight to the result. A list walks the
// RAM without the compare unit: it skips invalid entries and, for each valid
// entry, issues one RAM read and then emits the entry when the output register
// is free; a list of an empty table returns a single empty status.
// The block takes one request at a time: in_ready is high only while the
// sequencer idles, but a finished result sits in its own output register, so
// a new request is accepted while that result still waits for out_ready.
// Valid bits live in flip-flops and are cleared by reset; the entry RAM has no
// clearing pass. The timeout register sits at byte address 0 of the APB port.
module connection_table_idle_timeout #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  ctit_pkg::cmd_t    in_command,
  input  ctit_pkg::addr_t   in_address,
  input  ctit_pkg::port_t   in_port,
  input  ctit_pkg::pid_t    in_player_id_in,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output ctit_pkg::status_t out_status,
  output logic              out_is_new,
  output ctit_pkg::pid_t    out_player_id,
  output ctit_pkg::addr_t   out_address_out,
  output ctit_pkg::port_t   out_port_out,
  output logic [4:0]        out_removed_count,
  output logic              out_last
);
  import ctit_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_DONE    = 3'd2;
  localparam logic [2:0] S_LIST_RD = 3'd3;
  localparam logic [2:0] S_LIST_WT = 3'd4;

  logic [2:0]             state_r, state_nxt;
  cmd_t                   cmd_r, cmd_nxt;
  addr_t                  key_addr_r, key_addr_nxt;
  port_t                  key_port_r, key_port_nxt;
  pid_t                   key_pid_r, key_pid_nxt;
  logic [IW-1:0]          idx_r, idx_nxt;
  logic                   issue_done_r, issue_done_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]          cmp_idx_r, cmp_idx_nxt;
  logic                   found_r, found_nxt;
  logic [IW-1:0]          hit_idx_r, hit_idx_nxt;
  pid_t                   hit_pid_r, hit_pid_nxt;
  addr_t                  hit_addr_r, hit_addr_nxt;
  port_t                  hit_port_r, hit_port_nxt;
  logic                   free_found_r, free_found_nxt;
  logic [IW-1:0]          free_idx_r, free_idx_nxt;
  logic [CW-1:0]          rm_cnt_r, rm_cnt_nxt;
  logic [CW-1:0]          emit_cnt_r, emit_cnt_nxt;
  logic [CW-1:0]          vld_cnt_r, vld_cnt_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  tick_t                  now_r, now_nxt;
  pid_t                   next_pid_r, next_pid_nxt;
  tick_t                  timeout_r, timeout_nxt;

  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r;
  logic                   out_is_new_r;
  pid_t                   out_pid_r;
  addr_t                  out_addr_r;
  port_t                  out_port_r;
  logic [4:0]             out_removed_r;
  logic                   out_last_r;

  // Result being loaded into the output register this cycle.
  logic                   load_out;
  status_t                res_status;
  logic                   res_is_new;
  pid_t                   res_pid;
  addr_t                  res_addr;
  port_t                  res_port;
  logic [4:0]             res_removed;
  logic                   res_last;

  logic                   slot_free;
  logic                   cmp_v;
  logic [CW-1:0]          emit_inc;
  logic [CW+4:0]          rm_wide;

  logic                   ram_we;
  logic [IW-1:0]          ram_waddr;
  ent_t                   ram_wdata;
  logic [ENT_W-1:0]       ram_rdata;
  ent_t                   rd_ent;
  cmp_flags_t             flags;

  // ---------------------------------------------------------------------------
  // Entry storage and the shared compare unit
  // ---------------------------------------------------------------------------
  ctit_ram #(
    .W     (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign rd_ent = ent_t'(ram_rdata);

  ctit_cmp u_cmp (
    .ent      (rd_ent),
    .key_addr (key_addr_r),
    .key_port (key_port_r),
    .key_pid  (key_pid_r),
    .now      (now_r),
    .timeout  (timeout_r),
    .flags    (flags)
  );

  // ---------------------------------------------------------------------------
  // Handshake and configuration
  // ---------------------------------------------------------------------------
  assign in_ready  = (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_ready;
  assign pready    = 1'b1;
  assign prdata    = (paddr == 2'd0) ? timeout_r : 32'd0;

  // The RAM read at cmp_idx_r lands in the cycle after issue; its valid bit is
  // read from the flops at compare time.
  assign cmp_v    = valid_r[cmp_idx_r];
  assign emit_inc = emit_cnt_r + CW'(1);
  assign rm_wide  = {5'd0, rm_cnt_r};

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_addr_nxt   = key_addr_r;
    key_port_nxt   = key_port_r;
    key_pid_nxt    = key_pid_r;
    idx_nxt        = idx_r;
    issue_done_nxt = issue_done_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    found_nxt      = found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_pid_nxt    = hit_pid_r;
    hit_addr_nxt   = hit_addr_r;
    hit_port_nxt   = hit_port_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    rm_cnt_nxt     = rm_cnt_r;
    emit_cnt_nxt   = emit_cnt_r;
    vld_cnt_nxt    = vld_cnt_r;
    valid_nxt      = valid_r;
    now_nxt        = now_r;
    next_pid_nxt   = next_pid_r;
    timeout_nxt    = timeout_r;

    ram_we      = 1'b0;
    ram_waddr   = hit_idx_r;
    ram_wdata   = '{addr: key_addr_r, port: key_port_r, pid: hit_pid_r, seen: now_r};

    load_out    = 1'b0;
    res_status  = ST_OK;
    res_is_new  = 1'b0;
    res_pid     = '0;
    res_addr    = '0;
    res_port    = '0;
    res_removed = '0;
    res_last    = 1'b1;

    // Timeout write: the user writes only while idle; the block does not check.
    if (psel && penable && pwrite && pready && (paddr == 2'd0)) begin
      timeout_nxt = pwdata;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt        = in_command;
          key_addr_nxt   = in_address;
          key_port_nxt   = in_port;
          key_pid_nxt    = in_player_id_in;
          idx_nxt        = '0;
          issue_done_nxt = 1'b0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          rm_cnt_nxt     = '0;
          emit_cnt_nxt   = '0;
          unique case (in_command)
            CMD_PACKET, CMD_SWEEP, CMD_EP_FOR_ID, CMD_ID_FOR_EP: begin
              state_nxt = S_SCAN;
            end
            CMD_LIST: begin
              state_nxt = (vld_cnt_r == '0) ? S_DONE : S_LIST_RD;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue stage: advance the read address until the last entry is out.
        if (!issue_done_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = idx_r;
          if (idx_r == LAST_IDX) begin
            issue_done_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
        // Compare stage: keep lowest hit and free slot; a sweep clears expired.
        if (cmp_vld_r) begin
          if (!cmp_v && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = cmp_idx_r;
          end
          unique case (cmd_r)
            CMD_PACKET, CMD_ID_FOR_EP: begin
              if (cmp_v && flags.ep_hit && !found_r) begin
                found_nxt   = 1'b1;
                hit_idx_nxt = cmp_idx_r;
                hit_pid_nxt = rd_ent.pid;
              end
            end
            CMD_EP_FOR_ID: begin
              if (cmp_v && flags.id_hit && !found_r) begin
                found_nxt    = 1'b1;
                hit_addr_nxt = rd_ent.addr;
                hit_port_nxt = rd_ent.port;
              end
            end
            CMD_SWEEP: begin
              if (cmp_v && flags.expired) begin
                valid_nxt[cmp_idx_r] = 1'b0;
                rm_cnt_nxt           = rm_cnt_r + CW'(1);
              end
            end
            default: begin
            end
          endcase
          if (cmp_idx_r == LAST_IDX) begin
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        // Commit side effects together with the single result.
        if (slot_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
          unique case (cmd_r)
            CMD_PACKET: begin
              if (found_r) begin
                ram_we    = 1'b1;
                res_pid   = hit_pid_r;
                res_addr  = key_addr_r;
                res_port  = key_port_r;
              end else if (free_found_r) begin
                ram_we               = 1'b1;
                ram_waddr            = free_idx_r;
                ram_wdata.pid        = next_pid_r;
                valid_nxt[free_idx_r] = 1'b1;
                next_pid_nxt         = next_pid_r + 16'd1;
                vld_cnt_nxt          = vld_cnt_r + CW'(1);
                res_is_new           = 1'b1;
                res_pid              = next_pid_r;
                res_addr             = key_addr_r;
                res_port             = key_port_r;
              end else begin
                res_status = ST_FULL;
              end
            end
            CMD_TICK: begin
              now_nxt = now_r + 32'd1;
            end
            CMD_SWEEP: begin
              vld_cnt_nxt = vld_cnt_r - rm_cnt_r;
              res_removed = rm_wide[4:0];
            end
            CMD_EP_FOR_ID: begin
              if (found_r) begin
                res_pid  = key_pid_r;
                res_addr = hit_addr_r;
                res_port = hit_port_r;
              end else begin
                res_status = ST_NOT_FOUND;
              end
            end
            CMD_ID_FOR_EP: begin
              if (found_r) begin
                res_pid  = hit_pid_r;
                res_addr = key_addr_r;
                res_port = key_port_r;
              end else begin
                res_status = ST_NOT_FOUND;
              end
            end
            CMD_LIST: begin
              res_status = ST_EMPTY;
            end
            default: begin
            end
          endcase
        end
      end

      S_LIST_RD: begin
        // Skip invalid entries; the read of a valid one is issued here.
        if (valid_r[idx_r]) begin
          state_nxt = S_LIST_WT;
        end else if (idx_r != LAST_IDX) begin
          idx_nxt = idx_r + IW'(1);
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_LIST_WT: begin
        if (slot_free) begin
          load_out = 1'b1;
          res_pid  = rd_ent.pid;
          res_addr = rd_ent.addr;
          res_port = rd_ent.port;
          res_last = (emit_inc == vld_cnt_r);
          if (res_last || (idx_r == LAST_IDX)) begin
            state_nxt = S_IDLE;
          end else begin
            emit_cnt_nxt = emit_inc;
            idx_nxt      = idx_r + IW'(1);
            state_nxt    = S_LIST_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Output register: load a new result, else drop the taken one.
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      vld_cnt_r   <= '0;
      now_r       <= '0;
      next_pid_r  <= '0;
      timeout_r   <= TIMEOUT_RST;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      vld_cnt_r   <= vld_cnt_nxt;
      now_r       <= now_nxt;
      next_pid_r  <= next_pid_nxt;
      timeout_r   <= timeout_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
    end
  end

  // Request and scan payload: no reset needed.
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_addr_r   <= key_addr_nxt;
    key_port_r   <= key_port_nxt;
    key_pid_r    <= key_pid_nxt;
    idx_r        <= idx_nxt;
    issue_done_r <= issue_done_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    found_r      <= found_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_pid_r    <= hit_pid_nxt;
    hit_addr_r   <= hit_addr_nxt;
    hit_port_r   <= hit_port_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    rm_cnt_r     <= rm_cnt_nxt;
    emit_cnt_r   <= emit_cnt_nxt;
    if (load_out) begin
      out_status_r  <= res_status;
      out_is_new_r  <= res_is_new;
      out_pid_r     <= res_pid;
      out_addr_r    <= res_addr;
      out_port_r    <= res_port;
      out_removed_r <= res_removed;
      out_last_r    <= res_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_is_new        = out_is_new_r;
  assign out_player_id     = out_pid_r;
  assign out_address_out   = out_addr_r;
  assign out_port_out      = out_port_r;
  assign out_removed_count = out_removed_r;
  assign out_last          = out_last_r;

endmodule

[rtl/ctit_checker.sv]
// Port-level checker for connection_table_idle_timeout, bound to the top level.
// Depends on ctit_pkg.
module ctit_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input ctit_pkg::status_t out_status,
  input logic              out_is_new,
  input logic [4:0]        out_removed_count,
  input logic              out_last
);
  import ctit_pkg::*;

  // One request at a time: the sequencer leaves idle right after acceptance.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready held after a request was accepted");

  // Only list results can be non-final, and those always carry status ok.
  a_err_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_last)
    else $error("error status on a non-final result");

  a_new_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_new |-> (out_status == ST_OK) && out_last)
    else $error("new-entry result with bad status or not final");

  a_removed_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_removed_count != 5'd0) |-> out_last && !out_is_new)
    else $error("eviction count on a non-sweep result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_last))
    else $error("result dropped or changed while stalled");

endmodule

bind connection_table_idle_timeout ctit_checker u_ctit_checker (.*);
